@@ rtl/rfig_pkg.sv @@
// Shared constants, types and helper functions for the random force impulse generator.
// Used by rfig_sermul, rfig_cordic and random_force_impulse_gen; depends on nothing.
`default_nettype none

package rfig_pkg;

  // Field widths
  localparam int unsigned DT_W        = 24;
  localparam int unsigned STRENGTH_W  = 16;
  localparam int unsigned INTERVAL_W  = 24;
  localparam int unsigned RNG_W       = 32;
  localparam int unsigned FRAC_W      = 24;
  localparam int unsigned FORCE_W     = 17;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd2;

  // Generator and countdown
  localparam logic [RNG_W-1:0]      ZERO_SEED      = 32'h6D2B79F5;
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL   = 24'd1000;
  localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 24'd1000000;

  // Bit-serial multiplier: signed multiplicand times unsigned 24-bit multiplier
  localparam int unsigned MCAND_W   = 33;
  localparam int unsigned MUL_STEPS = 24;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int unsigned PROD_W    = MCAND_W + MUL_STEPS;

  // CORDIC
  localparam int unsigned CORDIC_STEPS = 18;
  localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned TRIG_W       = 32;
  localparam int unsigned ANGLE_W      = 24;
  localparam int unsigned Z_W          = 25;
  localparam int unsigned ATAN_W       = 22;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;

  // Rounding of a product to Q8.8
  localparam int unsigned ROUND_SHIFT = 38;
  localparam int unsigned V_W         = PROD_W - ROUND_SHIFT;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 57'sh2000000000;
  localparam logic signed [V_W-1:0]    FORCE_MAX  = 19'sd65535;
  localparam logic signed [V_W-1:0]    FORCE_MIN  = -19'sd65535;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c_val;
    logic signed [TRIG_W-1:0] s_val;
  } rfig_trig_t;

  // One xorshift32 step; a zero state is replaced before the shifts
  function automatic logic [RNG_W-1:0] rfig_xorshift(input logic [RNG_W-1:0] s);
    logic [RNG_W-1:0] v;
    v = (s == '0) ? ZERO_SEED : s;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

  // atan(2^-i) with a full turn equal to 2^24
  function automatic logic [ATAN_W-1:0] rfig_atan(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] a;
    case (i)
      5'd0:    a = 22'd2097152;
      5'd1:    a = 22'd1238021;
      5'd2:    a = 22'd654136;
      5'd3:    a = 22'd332050;
      5'd4:    a = 22'd166669;
      5'd5:    a = 22'd83416;
      5'd6:    a = 22'd41718;
      5'd7:    a = 22'd20860;
      5'd8:    a = 22'd10430;
      5'd9:    a = 22'd5215;
      5'd10:   a = 22'd2608;
      5'd11:   a = 22'd1304;
      5'd12:   a = 22'd652;
      5'd13:   a = 22'd326;
      5'd14:   a = 22'd163;
      5'd15:   a = 22'd81;
      5'd16:   a = 22'd41;
      5'd17:   a = 22'd20;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round half up by 2^38 and saturate to +-65535
  function automatic logic signed [FORCE_W-1:0] rfig_round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] r;
    logic signed [V_W-1:0]    v;
    r = p + ROUND_HALF;
    v = $signed(r[PROD_W-1:ROUND_SHIFT]);
    if (v > FORCE_MAX) begin
      return FORCE_W'(FORCE_MAX);
    end else if (v < FORCE_MIN) begin
      return FORCE_W'(FORCE_MIN);
    end
    return FORCE_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ rtl/rfig_sermul.sv @@
// Bit-serial shift-and-add multiplier: signed multiplicand, unsigned multiplier.
// Depends on rfig_pkg for widths.
`default_nettype none

module rfig_sermul
  import rfig_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [MCAND_W-1:0] mcand_i,
  input  logic [MUL_STEPS-1:0]      mplier_i,
  output logic                      busy_o,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic [MUL_CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [MCAND_W:0]   acc_q, acc_d, sum;
  logic [MUL_STEPS-1:0]      lo_q, lo_d;
  logic signed [MCAND_W-1:0] mcand_q, mcand_d;

  // add the multiplicand when the current multiplier bit is set, then shift right
  always_comb begin
    sum     = lo_q[0] ? (acc_q + {mcand_q[MCAND_W-1], mcand_q}) : acc_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    if (start_i) begin
      cnt_d   = MUL_CNT_W'(MUL_STEPS);
      acc_d   = '0;
      lo_d    = mplier_i;
      mcand_d = mcand_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      acc_d = {sum[MCAND_W], sum[MCAND_W:1]};
      lo_d  = {sum[0], lo_q[MUL_STEPS-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = {acc_q[MCAND_W-1:0], lo_q};

endmodule

`default_nettype wire

@@ rtl/rfig_cordic.sv @@
// Iterative rotation CORDIC, one micro-rotation a cycle, with quadrant folding.
// Depends on rfig_pkg for widths, the arctangent table and the trig struct.
`default_nettype none

module rfig_cordic
  import rfig_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ANGLE_W-1:0] angle_i,
  output logic               busy_o,
  output rfig_trig_t         trig_o
);

  logic                     busy_q, busy_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [1:0]               quad_q, quad_d;
  logic signed [TRIG_W-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [Z_W-1:0]    z_q, z_d, at;

  always_comb begin
    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    at     = $signed({{(Z_W-ATAN_W){1'b0}}, rfig_atan(step_q)});
    busy_d = busy_q;
    step_d = step_q;
    quad_d = quad_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      // nearest quadrant; residual is the low 22 bits read as signed
      busy_d = 1'b1;
      step_d = '0;
      quad_d = angle_i[ANGLE_W-1:ANGLE_W-2] + {1'b0, angle_i[ANGLE_W-3]};
      x_d    = CORDIC_X0;
      y_d    = '0;
      z_d    = $signed({{(Z_W-ANGLE_W+2){angle_i[ANGLE_W-3]}}, angle_i[ANGLE_W-3:0]});
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // rotate the result back into its quadrant
  always_comb begin
    case (quad_q)
      2'd0: begin
        trig_o.c_val = x_q;
        trig_o.s_val = y_q;
      end
      2'd1: begin
        trig_o.c_val = -y_q;
        trig_o.s_val = x_q;
      end
      2'd2: begin
        trig_o.c_val = -x_q;
        trig_o.s_val = -y_q;
      end
      default: begin
        trig_o.c_val = y_q;
        trig_o.s_val = -x_q;
      end
    endcase
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

@@ rtl/random_force_impulse_gen.sv @@
// Random force impulse generator: countdown, xorshift32 draws, CORDIC and serial multiplies.
// Depends on rfig_pkg, rfig_sermul and rfig_cordic.
//
// Usage:
//   Each request on the slave stream is one time tick: tdata carries dt_us (24 bit),
//   tuser carries the eligible flag. An ineligible tick or a tick with dt_us of zero
//   changes nothing and gives no result. Otherwise the countdown drops by dt_us; when
//   it runs out, two xorshift32 draws give a new angle and magnitude and the countdown
//   reloads to interval_us (at least 1000). The held force goes out on the master
//   stream whenever it is nonzero, with new_draw set if this tick drew it.
//   Throughput: one tick at a time. A tick without a draw passes through the emit state
//   into the output register. A tick with a draw is paced by the two 24-step
//   bit-serial multiplies (magnitude, then both components) run one after the other;
//   the 18-step CORDIC runs beside the first of them.
//   The result sits in an output register, so ready returns as soon as the work is
//   done even while the receiver stalls; a following result waits in the emit state.
//   Reset clears the countdown, the held force and the generator state, and sets the
//   registers to strength 0, interval 1000000 and seed 0. Writing the seed register
//   loads the generator state at once. Write configuration only while idle.
`default_nettype none

module random_force_impulse_gen
  import rfig_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // tick requests
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [23:0] dt_us
  input  logic [0:0]             s_axis_tuser,  // [0] eligible
  // force results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [16:0] force_x, [33:17] force_y, rest zero
  output logic [0:0]             m_axis_tuser   // [0] new_draw
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DRAW_A = 3'd1;
  localparam logic [2:0] S_DRAW_M = 3'd2;
  localparam logic [2:0] S_MAG    = 3'd3;
  localparam logic [2:0] S_COMP   = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [STRENGTH_W-1:0]     strength_q;
  logic [INTERVAL_W-1:0]     interval_q;
  logic [RNG_W-1:0]          rng_q, rng_next;
  logic [INTERVAL_W-1:0]     time_left_q, time_left_d, reload;
  logic                      drew_q, drew_d;
  logic signed [FORCE_W-1:0] cur_fx_q, cur_fx_d, cur_fy_q, cur_fy_d;
  logic                      m_valid_q, m_valid_d;
  logic signed [FORCE_W-1:0] out_fx_q, out_fy_q;
  logic                      out_draw_q;

  logic                      accept, tick_live, expired, force_nz, out_free, out_load;
  logic [DT_W-1:0]           dt;
  logic                      mag_done, cordic_start, mula_start;
  logic signed [MCAND_W-1:0] mula_mcand, mulb_mcand;
  logic [MUL_STEPS-1:0]      mula_mplier, m24;
  logic                      mula_busy, mulb_busy, cordic_busy;
  logic signed [PROD_W-1:0]  prod_a, prod_b;
  rfig_trig_t                trig;

  // ---------------------------------------------------------------------------
  // Configuration registers and generator state
  // ---------------------------------------------------------------------------
  assign rng_next = rfig_xorshift(rng_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= '0;
      interval_q <= RESET_INTERVAL;
      rng_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_STRENGTH: strength_q <= cfg_wdata_i[STRENGTH_W-1:0];
          REG_INTERVAL: interval_q <= cfg_wdata_i[INTERVAL_W-1:0];
          REG_SEED:     rng_q      <= cfg_wdata_i[RNG_W-1:0];
          default:      ;  // unknown index: drop the write
        endcase
      end else if (state_q == S_DRAW_A || state_q == S_DRAW_M) begin
        rng_q <= rng_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tick decision
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign dt            = s_axis_tdata[DT_W-1:0];
  assign tick_live     = s_axis_tuser[0] && (dt != '0);
  // countdown runs out when the remaining time is no more than dt
  assign expired       = (dt >= time_left_q);
  assign reload        = (interval_q < MIN_INTERVAL) ? MIN_INTERVAL : interval_q;

  // ---------------------------------------------------------------------------
  // Arithmetic units: angle draw starts the CORDIC, magnitude draw starts
  // multiplier A; both components then run on A and B side by side.
  // ---------------------------------------------------------------------------
  assign mag_done     = (state_q == S_MAG) && !mula_busy && !cordic_busy;
  assign cordic_start = (state_q == S_DRAW_A);
  assign mula_start   = (state_q == S_DRAW_M) || mag_done;
  assign m24          = prod_a[STRENGTH_W+MUL_STEPS-1:STRENGTH_W];

  assign mula_mcand  = (state_q == S_MAG) ? $signed({trig.c_val[TRIG_W-1], trig.c_val})
                                          : $signed({{(MCAND_W-STRENGTH_W){1'b0}}, strength_q});
  assign mula_mplier = (state_q == S_MAG) ? m24 : rng_next[FRAC_W-1:0];
  assign mulb_mcand  = $signed({trig.s_val[TRIG_W-1], trig.s_val});

  rfig_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (rng_next[ANGLE_W-1:0]),
    .busy_o  (cordic_busy),
    .trig_o  (trig)
  );

  rfig_sermul u_mul_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mula_start),
    .mcand_i  (mula_mcand),
    .mplier_i (mula_mplier),
    .busy_o   (mula_busy),
    .prod_o   (prod_a)
  );

  rfig_sermul u_mul_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mag_done),
    .mcand_i  (mulb_mcand),
    .mplier_i (m24),
    .busy_o   (mulb_busy),
    .prod_o   (prod_b)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign force_nz = (cur_fx_q != '0) || (cur_fy_q != '0);
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == S_EMIT) && force_nz && out_free;

  always_comb begin
    state_d     = state_q;
    time_left_d = time_left_q;
    drew_d      = drew_q;
    cur_fx_d    = cur_fx_q;
    cur_fy_d    = cur_fy_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && tick_live) begin
          if (expired) begin
            time_left_d = reload;
            drew_d      = 1'b1;
            state_d     = S_DRAW_A;
          end else begin
            time_left_d = time_left_q - dt;
            drew_d      = 1'b0;
            state_d     = S_EMIT;
          end
        end
      end
      S_DRAW_A: state_d = S_DRAW_M;
      S_DRAW_M: state_d = S_MAG;
      S_MAG: begin
        if (mag_done) begin
          state_d = S_COMP;
        end
      end
      S_COMP: begin
        if (!mula_busy && !mulb_busy) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        cur_fx_d = rfig_round_sat(prod_a);
        cur_fy_d = rfig_round_sat(prod_b);
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free; a zero force gives nothing
        if (!force_nz || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_left_q <= '0;
      drew_q      <= 1'b0;
      cur_fx_q    <= '0;
      cur_fy_q    <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_left_q <= time_left_d;
      drew_q      <= drew_d;
      cur_fx_q    <= cur_fx_d;
      cur_fy_q    <= cur_fy_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fx_q   <= cur_fx_q;
      out_fy_q   <= cur_fy_q;
      out_draw_q <= drew_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-2*FORCE_W){1'b0}}, out_fy_q, out_fx_q};
  assign m_axis_tuser  = out_draw_q;

`ifndef SYNTH
  // a result never carries a zero force
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_fx_q != '0) || (out_fy_q != '0))
    else $error("zero force presented on the result stream");

  // after a draw the countdown has been reloaded to at least the minimum interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> time_left_q >= MIN_INTERVAL)
    else $error("countdown not reloaded on a draw");

  // both component multiplies start together and so finish together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMP |-> mula_busy == mulb_busy)
    else $error("component multipliers out of step");

  // the output register only fills from the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_EMIT)
    else $error("result loaded outside the emit state");

  // the CORDIC is finished before the components are started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_done |=> !cordic_busy && mula_busy && mulb_busy)
    else $error("component multiplies started on an unfinished rotation");
`endif

endmodule

`default_nettype wire

@@ tb/random_force_impulse_gen_tb.sv @@
// Self-checking testbench for random_force_impulse_gen: tick requests in, force results out.
// Holds its own countdown, xorshift32 and CORDIC predictor; depends on rfig_pkg and the RTL.
`timescale 1ns / 100ps

module random_force_impulse_gen_tb;
  import rfig_pkg::*;

  // Run shape
  localparam int RAND_ITEMS    = 1050;  // ticks in the random part
  localparam int IDLE_PCT      = 18;    // chance of an idle cycle on either side
  localparam int SETTLE_CYCLES = 110;   // long enough for a draw still in flight to finish
  localparam int WATCHDOG_MAX  = 2000;  // cycles without any handshake before giving up
  localparam int N_DIR         = 26;

  // Register index the block does not decode; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Predictor constants
  localparam logic [31:0] XS_ZERO_SUB = 32'h6D2B79F5;
  localparam longint      COS_START   = 64'sd652032874;
  localparam longint      QUARTER     = 64'sd4194304;
  localparam longint      HALF_TURN   = 64'sd8388608;
  localparam longint      FULL_TURN   = 64'sd16777216;
  localparam longint      FORCE_LIM   = 64'sd65535;
  localparam int          MIN_RELOAD  = 1000;

  typedef enum logic [1:0] {ROW_TICK, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT} row_chk_e;

  typedef struct packed {
    row_kind_e                 kind;
    row_chk_e                  chk;   // CHK_SILENT: the tick must give no result
    logic [DT_W-1:0]           dt;
    logic                      el;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     val;
  } stim_row_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
    logic                      nd;
  } force_res_t;

  // Clock, reset and block inputs, all known from time zero
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [23:0] dt_us
  logic [0:0]             s_axis_tuser  = '0;  // [0] eligible
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [16:0] force_x, [33:17] force_y, rest zero
  logic [0:0]             m_axis_tuser;        // [0] new_draw

  // Predictor state and its copy of the registers
  logic [31:0]               pred_time_left = '0;
  logic [31:0]               pred_rng       = '0;
  logic signed [FORCE_W-1:0] pred_fx        = '0;
  logic signed [FORCE_W-1:0] pred_fy        = '0;
  logic [STRENGTH_W-1:0]     pred_strength  = '0;
  logic [INTERVAL_W-1:0]     pred_interval  = 24'd1000000;

  longint atan_lut [18] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                            10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20};

  force_res_t pending_forces [$];  // forces still owed by the block, oldest first
  stim_row_t  dir_rows [N_DIR];
  int         err_cnt = 0;
  bit         no_idle = 1'b0;      // set for the stretch with no idling on either side
  bit         dirty   = 1'b0;      // a tick went in since the block last settled

  random_force_impulse_gen uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // xorshift32 with the zero state swapped for a fixed constant first
  function automatic logic [31:0] xs_step(input logic [31:0] s);
    logic [31:0] v;
    v = (s == 32'd0) ? XS_ZERO_SUB : s;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

  // Snap the angle to the nearest quadrant, rotate the residual, then fold back
  function automatic void rotate(input logic [FRAC_W-1:0] ang, output longint c,
                                 output longint s);
    logic [FRAC_W:0] qsum;
    logic [1:0]      q;
    longint          z, x, y, dx, dy;
    qsum = {1'b0, ang} + 25'h200000;
    q    = qsum[23:22];
    z    = longint'(ang) - longint'(q) * QUARTER;
    if (z >= HALF_TURN) z -= FULL_TURN;
    x = COS_START;
    y = 0;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // Scale Q1.30 trig by the 24-bit magnitude, round half up to Q8.8, clip
  function automatic logic signed [FORCE_W-1:0] to_q88(input longint m24, input longint trig);
    longint v;
    v = (m24 * trig + (longint'(1) <<< 37)) >>> 38;
    if (v > FORCE_LIM) v = FORCE_LIM;
    if (v < -FORCE_LIM) v = -FORCE_LIM;
    return v[FORCE_W-1:0];
  endfunction

  // Advance the predicted state by one tick; returns 1 when a force is due
  function automatic bit predict_tick(input logic [DT_W-1:0] dt, input bit el,
                                      output force_res_t res);
    longint          t, m24, c, s;
    logic [FRAC_W-1:0] ang, frac;
    bit              drew;
    res  = '0;
    drew = 1'b0;
    if (!el || dt == '0) return 1'b0;
    t = longint'(pred_time_left) - longint'(dt);
    if (t <= 0) begin
      pred_rng = xs_step(pred_rng);
      ang      = pred_rng[FRAC_W-1:0];
      pred_rng = xs_step(pred_rng);
      frac     = pred_rng[FRAC_W-1:0];
      m24      = (longint'(pred_strength) * longint'(frac)) >>> 16;
      rotate(ang, c, s);
      pred_fx  = to_q88(m24, c);
      pred_fy  = to_q88(m24, s);
      pred_time_left = (pred_interval > MIN_RELOAD) ? 32'(pred_interval) : 32'(MIN_RELOAD);
      drew     = 1'b1;
    end else begin
      pred_time_left = t[31:0];
    end
    if (pred_fx == '0 && pred_fy == '0) return 1'b0;
    res.fx = pred_fx;
    res.fy = pred_fy;
    res.nd = drew;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Drop valid and hold until every owed force has come out
  task automatic hold_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk_i);
  endtask

  // Make the block idle: drain results, then wait out a draw that may give none
  task automatic settle();
    if (dirty) begin
      hold_for_results();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      dirty = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    // Mirror the write; bits above each register's width are dropped
    case (idx)
      REG_STRENGTH: pred_strength = val[STRENGTH_W-1:0];
      REG_INTERVAL: pred_interval = val[INTERVAL_W-1:0];
      REG_SEED:     pred_rng      = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offer one tick request; predict once accepted, then maybe idle a while.
  // Valid stays high on return when no idle cycle was taken, so that a following request runs back to back.
  task automatic send_tick(input logic [DT_W-1:0] dt, input bit el, input bit silent);
    force_res_t res;
    bit         due;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dt;
    s_axis_tuser  <= el;
    do @(posedge clk_i); while (!s_axis_tready);
    due   = predict_tick(dt, el, res);
    dirty = 1'b1;
    if (due && !silent) pending_forces.push_back(res);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every accepted force with the oldest one owed
  always @(posedge clk_i) begin : force_check
    force_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.fx = m_axis_tdata[FORCE_W-1:0];
      got.fy = m_axis_tdata[2*FORCE_W-1:FORCE_W];
      got.nd = m_axis_tuser[0];
      if (pending_forces.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected force, expected none, actual x=%0d y=%0d new=%0d",
                 $time, got.fx, got.fy, got.nd);
      end else begin
        want = pending_forces.pop_front();
        if (got.fx !== want.fx || got.fy !== want.fy || got.nd !== want.nd) begin
          err_cnt++;
          $display({"%0t: force mismatch, expected x=%0d y=%0d new=%0d, ",
                    "actual x=%0d y=%0d new=%0d"},
                   $time, want.fx, want.fy, want.nd, got.fx, got.fy, got.nd);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on either side restarts the count
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_MAX) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [DT_W-1:0]       dt;
    logic                  el;
    logic [CFG_DATA_W-1:0] wd;
    int                    counted, phase_len, r;
    bit                    held;

    // Directed part. Rows marked CHK_SILENT must give no result: strength still at
    // its reset value of zero, ineligible ticks and zero-length ticks.
    dir_rows = '{
      // after reset: a draw happens but the force stays zero
      '{ROW_TICK, CHK_SILENT, 24'd1,        1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_SILENT, 24'hFFFFFF,   1'b0, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_SILENT, 24'd0,        1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_SILENT, 24'hFFFFFF,   1'b1, REG_STRENGTH, 32'd0},
      // full strength, short interval clamped up, zero seed; junk in the upper bits
      '{ROW_CFG,  CHK_MODEL,  24'd0,        1'b0, REG_STRENGTH, 32'hABCDFFFF},
      '{ROW_CFG,  CHK_MODEL,  24'd0,        1'b0, REG_INTERVAL, 32'hFF000000},
      '{ROW_CFG,  CHK_MODEL,  24'd0,        1'b0, REG_SEED,     32'h00000000},
      // one short of expiry with zero force held, then expiry exactly at zero
      '{ROW_TICK, CHK_MODEL,  24'd999999,   1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_MODEL,  24'd1,        1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_MODEL,  24'd1,        1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_SILENT, 24'd1,        1'b0, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_SILENT, 24'd0,        1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_MODEL,  24'd998,      1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_MODEL,  24'hFFFFFF,   1'b1, REG_STRENGTH, 32'd0},
      // undecoded index, all-ones seed, longest interval
      '{ROW_CFG,  CHK_MODEL,  24'd0,        1'b0, REG_UNUSED,   32'hFFFFFFFF},
      '{ROW_CFG,  CHK_MODEL,  24'd0,        1'b0, REG_SEED,     32'hFFFFFFFF},
      '{ROW_CFG,  CHK_MODEL,  24'd0,        1'b0, REG_INTERVAL, 32'h00FFFFFF},
      '{ROW_TICK, CHK_MODEL,  24'd1000,     1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_MODEL,  24'hFFFFFE,   1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_MODEL,  24'd1,        1'b1, REG_STRENGTH, 32'd0},
      // smallest nonzero strength, interval just below the clamp
      '{ROW_CFG,  CHK_MODEL,  24'd0,        1'b0, REG_STRENGTH, 32'h00000001},
      '{ROW_CFG,  CHK_MODEL,  24'd0,        1'b0, REG_INTERVAL, 32'h5A0003E7},
      '{ROW_TICK, CHK_MODEL,  24'hFFFFFF,   1'b1, REG_STRENGTH, 32'd0},
      '{ROW_CFG,  CHK_MODEL,  24'd0,        1'b0, REG_STRENGTH, 32'h00008000},
      '{ROW_TICK, CHK_MODEL,  24'd500,      1'b1, REG_STRENGTH, 32'd0},
      '{ROW_TICK, CHK_MODEL,  24'd500,      1'b1, REG_STRENGTH, 32'd0}
    };

    // Hold reset, then release it once
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_tick(dir_rows[i].dt, dir_rows[i].el, dir_rows[i].chk == CHK_SILENT);
      end
    end

    // Random part: phases of fresh settings, each followed by a run of ticks
    counted = 0;
    held    = 1'b0;
    while (counted < RAND_ITEMS) begin
      if ($urandom_range(3) != 0) begin
        wd = $urandom;
        case ($urandom_range(7))
          0: wd[15:0] = 16'h0000;
          1: wd[15:0] = 16'hFFFF;
          2: wd[15:0] = 16'h0001;
          default: wd[15:0] = 16'($urandom);
        endcase
        write_reg(REG_STRENGTH, wd);
      end
      if ($urandom_range(3) != 0) begin
        wd = $urandom;
        case ($urandom_range(9))
          0: wd[23:0] = 24'd0;
          1: wd[23:0] = 24'd999;
          2: wd[23:0] = 24'd1000;
          3: wd[23:0] = 24'hFFFFFF;
          default: wd[23:0] = 24'($urandom_range(1000, 20000));
        endcase
        write_reg(REG_INTERVAL, wd);
      end
      if ($urandom_range(1) != 0) begin
        case ($urandom_range(5))
          0: wd = 32'h00000000;
          1: wd = 32'hFFFFFFFF;
          default: wd = $urandom;
        endcase
        write_reg(REG_SEED, wd);
      end
      if ($urandom_range(9) == 0) write_reg(REG_UNUSED, $urandom);

      phase_len = $urandom_range(30, 120);
      for (int k = 0; k < phase_len && counted < RAND_ITEMS; k++) begin
        no_idle = (counted >= 450) && (counted < 600);
        // Pause the sender once mid-run until every owed force is out
        if (!held && counted >= 300) begin
          held = 1'b1;
          hold_for_results();
        end
        r  = $urandom_range(99);
        el = 1'b1;
        dt = DT_W'($urandom_range(1, 1500));
        if (r < 8) begin
          el = 1'b0;
          dt = DT_W'($urandom);
        end else if (r < 14) begin
          dt = '0;
        end else if (r < 24) begin
          dt = DT_W'($urandom);
        end else if (r < 30) begin
          dt = '1;
        end else if (r < 36) begin
          dt = DT_W'($urandom_range(1, 16));
        end
        send_tick(dt, el, 1'b0);
        counted++;
      end
    end
    no_idle = 1'b0;

    // Drain, then give any draw still in flight time to show a stray result
    settle();
    if (pending_forces.size() != 0) begin
      err_cnt++;
      $display("%0t: forces missing, expected %0d more, actual none",
               $time, pending_forces.size());
    end
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
